FILE: src/assert_macros.svh
// Assertion macros shared by the RTL files.
// Depends on nothing; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("assert failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("assert failed");
`else
`define ASSERT_IMPL(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: src/lmjm_pkg.sv
// Shared constants and types for the Jelinek-Mercer term scorer.
// Depends on nothing.
package lmjm_pkg;
  localparam int SECTIONS   = 4;
  localparam int SEC_W      = 2;
  localparam int VOCAB_SIZE = 4096;
  localparam int TERM_W     = 12;
  localparam int DOC_TERMS  = 64;
  localparam int CNT_W      = 7;
  localparam int IDX_W      = 6;
  localparam int SCORE_FRAC = 16;
  localparam int CF_ADDR_W  = SEC_W + TERM_W;
  localparam int CF_DEPTH   = SECTIONS * VOCAB_SIZE;
  localparam logic [35:0] LN2_Q28 = 36'd186065279;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TERM = 1'b1;

  typedef struct packed {
    logic start;
    logic [43:0] num;
    logic [43:0] den;
  } lmjm_div_req_t;
endpackage

FILE: src/lmjm_div.sv
// Bit-serial divider: floor(num*2^32/den) clamped to 2^32, one bit per cycle.
// Depends on lmjm_pkg.
module lmjm_div
  import lmjm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  lmjm_div_req_t req,
  output logic          done,
  output logic [32:0]   quot
);
  logic [44:0] rem;
  logic [43:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic [45:0] rem2;

  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        den <= req.den;
        rem <= {1'b0, req.num};
        quot <= '0;
        cnt <= '0;
        if (req.num >= req.den) begin
          quot <= 33'h1_0000_0000;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (rem2 >= {2'b0, den}) begin
          rem <= 45'(rem2 - {2'b0, den});
          quot <= {quot[31:0], 1'b1};
        end else begin
          rem <= rem2[44:0];
          quot <= {quot[31:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: src/lmjm_log.sv
// Iterative log unit: magnitude of ln(r/2^32) in Q.SCORE_FRAC, saturated to 2^23.
// Depends on lmjm_pkg.
module lmjm_log
  import lmjm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] ratio,
  output logic        done,
  output logic [23:0] mag
);
  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_MUL, L_PRD, L_RND} lstate_t;
  lstate_t st;
  logic [32:0] r;
  logic [5:0]  e;
  logic [31:0] x;
  logic [29:0] frac;
  logic [4:0]  it;
  logic [63:0] sq;
  logic [32:0] x2;
  logic [36:0] mag2;
  logic [72:0] prod;
  logic [72:0] rnd;

  localparam int SH = 58 - SCORE_FRAC;

  assign sq = 64'(x) * 64'(x);
  assign x2 = sq[62:30];
  assign rnd = prod + (73'd1 << (SH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        L_IDLE: begin
          if (start) begin
            r <= ratio;
            e <= 6'd32;
            st <= L_NORM;
          end
        end
        L_NORM: begin
          // step down one bit a cycle to find the leading one
          if (r[e[5:0]] || e == 6'd0) begin
            if (e >= 6'd30) x <= 32'(r >> (e - 6'd30));
            else x <= 32'(r << (6'd30 - e));
            frac <= '0;
            it <= '0;
            st <= L_SQ;
          end else begin
            e <= e - 6'd1;
          end
        end
        L_SQ: begin
          if (x2[31]) begin
            x <= x2[32:1];
            frac <= {frac[28:0], 1'b1};
          end else begin
            x <= x2[31:0];
            frac <= {frac[28:0], 1'b0};
          end
          it <= it + 5'd1;
          if (it == 5'd29) st <= L_MUL;
        end
        L_MUL: begin
          mag2 <= ({31'd0, 6'd32 - e} << 30) - {7'd0, frac};
          st <= L_PRD;
        end
        L_PRD: begin
          // scale log2 by ln2
          prod <= 73'(mag2) * 73'(LN2_Q28);
          st <= L_RND;
        end
        L_RND: begin
          if ((rnd >> SH) > 73'h80_0000) mag <= 24'h80_0000;
          else mag <= rnd[SH+23:SH];
          done <= 1'b1;
          st <= L_IDLE;
        end
        default: st <= L_IDLE;
      endcase
    end
  end
endmodule

FILE: src/lm_term_score_jelinek_mercer_unit.sv
// Jelinek-Mercer term scorer top level; uses lmjm_div, lmjm_log and lmjm_pkg.
// Holds the frequency memory, document buffer and the scoring sequencer.
// Load requests (operation 0) write a collection frequency into a 16K-entry
// memory and keep per-section totals; term requests (operation 1) are
// buffered (up to 64) and summed into per-section document lengths. The term
// request flagged by tlast scores every buffered term in order, emitting
// ln(lambda*tf/doclen + (1-lambda)*cf/total) in signed Q7.16. After reset a
// clearing pass zeroes the frequency memory; no request is taken then. A load
// reads, modifies and writes its memory entry. Scoring one term reads it,
// sets up, runs both divisions on the shared divider, mixes, runs the log
// unit and outputs. Each division runs start, 32 quotient bits and done, or
// skips the quotient bits when the numerator reaches the denominator; the
// log unit runs start, a leading-one search, 30 squaring steps, then forms,
// scales and rounds, then done. A term with a zero denominator skips both
// divisions and the log unit. Scoring waits while a result is held. tuser in:
// operation. tdata in: section, term_id, amount (bits 1:0,13:2,45:14); tlast:
// last_item. tdata out: section_out, term_out, score (1:0,13:2,37:14);
// tuser out: invalid_score; tlast: last_result.
`include "assert_macros.svh"
module lm_term_score_jelinek_mercer_unit
  import lmjm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        lambda_weight_we,
  input  logic [16:0] lambda_weight,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // section, term_id, amount, pad
  input  logic        s_axis_tuser,   // operation
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // section_out, term_out, score, pad
  output logic        m_axis_tuser,   // invalid_score
  output logic        m_axis_tlast
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LD_RD, S_LD_WR, S_SC_RD, S_SC_CF, S_DIV1, S_DIV2,
    S_MIX, S_LOG, S_OUT
  } state_t;

  state_t st;
  logic [16:0] lam_reg;
  logic [31:0] cf_mem [CF_DEPTH];
  logic [31:0] cf_rd;
  logic [CF_ADDR_W-1:0] cf_addr;
  logic [CF_ADDR_W:0]   clr_cnt;
  logic [45:0] buf_mem [DOC_TERMS];
  logic [45:0] buf_rd;
  logic [43:0] coll_total [SECTIONS];
  logic [37:0] doc_length [SECTIONS];
  logic [CNT_W-1:0] doc_count;
  logic [CNT_W-1:0] k;
  logic [31:0] amt;
  logic [SEC_W-1:0] sec;
  logic [TERM_W-1:0] term;
  logic [32:0] qd;
  logic [16:0] lam;
  logic [50:0] mix;
  logic [32:0] ratio;
  lmjm_div_req_t dreq;
  logic ddone;
  logic [32:0] dq;
  logic lstart, ldone;
  logic [23:0] lmag;
  logic in_op, in_last;
  logic [SEC_W-1:0] in_sec;
  logic [TERM_W-1:0] in_term;
  logic [31:0] in_amt;

  assign in_op   = s_axis_tuser;
  assign in_sec  = s_axis_tdata[1:0];
  assign in_term = s_axis_tdata[13:2];
  assign in_amt  = s_axis_tdata[45:14];
  assign in_last = s_axis_tlast;
  assign s_axis_tready = (st == S_IDLE);

  lmjm_div u_div (.clk, .rst, .req(dreq), .done(ddone), .quot(dq));
  lmjm_log u_log (.clk, .rst, .start(lstart), .ratio(ratio), .done(ldone), .mag(lmag));

  // frequency memory: one write port and one read port
  always_ff @(posedge clk) begin
    if (st == S_CLR) cf_mem[clr_cnt[CF_ADDR_W-1:0]] <= '0;
    else if (st == S_LD_WR) cf_mem[cf_addr] <= amt;
    cf_rd <= cf_mem[cf_addr];
  end

  always_ff @(posedge clk) begin
    if (st == S_IDLE && s_axis_tvalid && in_op == OP_TERM && doc_count < CNT_W'(DOC_TERMS))
      buf_mem[doc_count[IDX_W-1:0]] <= {in_sec, in_term, in_amt};
    buf_rd <= buf_mem[k[IDX_W-1:0]];
  end

  assign lam = (lam_reg > 17'd65536) ? 17'd65536 : lam_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR;
      clr_cnt <= '0;
      lam_reg <= 17'd32768;
      doc_count <= '0;
      k <= '0;
      m_axis_tvalid <= 1'b0;
      dreq.start <= 1'b0;
      lstart <= 1'b0;
      for (int i = 0; i < SECTIONS; i++) begin
        coll_total[i] <= '0;
        doc_length[i] <= '0;
      end
    end else begin
      dreq.start <= 1'b0;
      lstart <= 1'b0;
      if (lambda_weight_we) lam_reg <= lambda_weight;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (st)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (CF_ADDR_W+1)'(CF_DEPTH - 1)) st <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            sec <= in_sec;
            amt <= in_amt;
            cf_addr <= {in_sec, in_term};
            if (in_op == OP_LOAD) begin
              st <= S_LD_RD;
            end else begin
              if (doc_count < CNT_W'(DOC_TERMS)) begin
                doc_count <= doc_count + 1'b1;
                doc_length[in_sec] <= doc_length[in_sec] + 38'(in_amt);
              end
              k <= '0;
              if (in_last) st <= S_SC_RD;
            end
          end
        end
        S_LD_RD: st <= S_LD_WR;
        S_LD_WR: begin
          // add new, subtract old
          coll_total[sec] <= coll_total[sec] + 44'(amt) - 44'(cf_rd);
          st <= S_IDLE;
        end
        S_SC_RD: begin
          if (k == doc_count) begin
            doc_count <= '0;
            for (int i = 0; i < SECTIONS; i++) doc_length[i] <= '0;
            st <= S_IDLE;
          end else if (!m_axis_tvalid) begin
            st <= S_SC_CF;
          end
        end
        S_SC_CF: begin
          sec <= buf_rd[45:44];
          term <= buf_rd[43:32];
          cf_addr <= buf_rd[45:32];
          if (doc_length[buf_rd[45:44]] == '0 || coll_total[buf_rd[45:44]] == '0) begin
            ratio <= '0;
            st <= S_OUT;
          end else begin
            dreq.start <= 1'b1;
            dreq.num <= 44'(buf_rd[31:0]);
            dreq.den <= 44'(doc_length[buf_rd[45:44]]);
            st <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (ddone) begin
            qd <= dq;
            dreq.start <= 1'b1;
            dreq.num <= 44'(cf_rd);
            dreq.den <= coll_total[sec];
            st <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (ddone) begin
            mix <= 51'(lam) * 51'(qd) + 51'(17'd65536 - lam) * 51'(dq);
            st <= S_MIX;
          end
        end
        S_MIX: begin
          ratio <= mix[48:16];
          if (mix[48:16] != '0) begin
            lstart <= 1'b1;
            st <= S_LOG;
          end else begin
            st <= S_OUT;
          end
        end
        S_LOG: begin
          if (ldone) st <= S_OUT;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata[1:0] <= sec;
          m_axis_tdata[13:2] <= term;
          m_axis_tdata[37:14] <= (ratio == '0) ? 24'h80_0000 : 24'(-lmag);
          m_axis_tdata[39:38] <= 2'b00;
          m_axis_tuser <= (ratio == '0);
          m_axis_tlast <= (k + 1'b1 == doc_count);
          k <= k + 1'b1;
          st <= S_SC_RD;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_cnt_max, clk, rst, doc_count <= CNT_W'(DOC_TERMS))
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_IMPL(a_no_take_busy, clk, rst, !(s_axis_tready && m_axis_tvalid && st != S_IDLE))
endmodule
